>>> src/ipv4_five_tuple_header_parser_macros.svh
// Assertion macros for the IPv4 five-tuple header parser.
// Included by the top level; every macro samples aclk and is disabled while aresetn is low.
`ifndef IPV4_FIVE_TUPLE_HEADER_PARSER_MACROS_SVH
`define IPV4_FIVE_TUPLE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication check.
`define IPV4FT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ipv4ft: same-cycle check failed");

// Next-cycle implication check.
`define IPV4FT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ipv4ft: next-cycle check failed");

`endif

>>> src/ipv4ft_pkg.sv
// Shared types and constants for the IPv4 five-tuple header parser.
// No dependencies; imported by every module of the block.
package ipv4ft_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 128;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TAG_A_RESET = 16'h8100;
    localparam logic [15:0] TAG_B_RESET = 16'h88A8;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [6:0]  TCP_HDR_LEN = 7'd20;
    localparam logic [6:0]  UDP_HDR_LEN = 7'd8;
    localparam logic [6:0]  IP_MIN_LEN  = 7'd20;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TAG_A = 1'b0,
        CFG_TAG_B = 1'b1
    } cfg_index_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_PARSED   = 2'd0,
        ST_NOT_IPV4 = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_BAD_HDR  = 2'd3
    } status_t;

    // One frame byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } in_beat_t;

    // One result, ordered so that the last field lands in the lowest bits.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [7:0]  ip_protocol;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        status_t     parse_status;
    } result_t;

endpackage

>>> src/ipv4ft_in_stage.sv
// Input register of the IPv4 five-tuple header parser.
// Holds one accepted frame byte until the parse stage consumes it; uses ipv4ft_pkg.
module ipv4ft_in_stage import ipv4ft_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 consume,
    output in_beat_t             beat
);

    logic       valid_reg;
    logic       last_reg;
    logic [7:0] data_reg;

    // A new byte may enter when the register is empty or is drained this cycle.
    assign s_tready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            last_reg <= s_tlast;
            data_reg <= s_tdata;
        end
    end

    assign beat = '{valid: valid_reg, last: last_reg, data: data_reg};

endmodule

>>> src/ipv4ft_parser.sv
// Per-byte header parse stage of the IPv4 five-tuple header parser.
// Tracks frame position, strips VLAN tags, captures IPv4/L4 fields, forms the result.
// Uses ipv4ft_pkg.
module ipv4ft_parser import ipv4ft_pkg::*; #(
    parameter int MAX_VLAN_TAGS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] tag_type_a,
    input  logic [15:0] tag_type_b,
    input  in_beat_t    beat,
    input  logic        out_free,
    output logic        consume,
    output logic        res_load,
    output result_t     res
);

    localparam int TAG_W = (MAX_VLAN_TAGS > 1) ? 2 : 1;
    localparam int L3_W  = $clog2(14 + 4 * MAX_VLAN_TAGS + 1);
    localparam logic [L3_W-1:0]  L3_BASE  = L3_W'(14);
    localparam logic [L3_W-1:0]  TAG_LEN  = L3_W'(4);
    localparam logic [TAG_W-1:0] MAX_TAGS = TAG_W'(MAX_VLAN_TAGS);

    typedef enum logic [1:0] {
        PH_ETH,
        PH_IP,
        PH_OTHER
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic [TAG_W-1:0] tags_reg, tags_next;
    logic [L3_W-1:0]  l3_reg, l3_next;
    logic [7:0]       etype_hi_reg, etype_hi_next;
    logic             ver_ok_reg, ver_ok_next;
    logic [5:0]       ihl_reg, ihl_next;
    logic             frag_hi_reg, frag_hi_next;
    logic             frag_lo_reg, frag_lo_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      src_addr_reg, src_addr_next;
    logic [31:0]      dst_addr_reg, dst_addr_next;
    logic [15:0]      src_port_reg, src_port_next;
    logic [15:0]      dst_port_reg, dst_port_next;

    logic [15:0] l3_ext;
    logic [15:0] ip_off;
    logic [6:0]  port_off;
    logic [15:0] etype;
    logic        is_tag;
    logic [15:0] len;
    logic [6:0]  l3_new;
    logic [6:0]  need;
    logic [6:0]  ip_min_end;
    logic [6:0]  hdr_end;
    logic [6:0]  l4_end;
    logic        ports_ok;
    status_t     status;

    // A last byte waits here while the result register still holds an untaken result.
    assign consume  = beat.valid && (!beat.last || out_free);
    assign res_load = consume && beat.last;

    assign l3_ext   = {{(16 - L3_W){1'b0}}, l3_reg};
    assign ip_off   = cnt_reg - l3_ext;
    assign port_off = {1'b0, ip_off[5:0]} - {1'b0, ihl_reg};
    assign etype    = {etype_hi_reg, beat.data};
    assign is_tag   = (etype == tag_type_a || etype == tag_type_b) && (tags_reg < MAX_TAGS);
    assign cnt_next = (cnt_reg != COUNT_MAX) ? cnt_reg + 16'd1 : cnt_reg;

    always_comb begin
        phase_next    = phase_reg;
        tags_next     = tags_reg;
        l3_next       = l3_reg;
        etype_hi_next = etype_hi_reg;
        ver_ok_next   = ver_ok_reg;
        ihl_next      = ihl_reg;
        frag_hi_next  = frag_hi_reg;
        frag_lo_next  = frag_lo_reg;
        proto_next    = proto_reg;
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        unique case (phase_reg)
            PH_ETH: begin
                if (cnt_reg == l3_ext - 16'd2) begin
                    etype_hi_next = beat.data;
                end else if (cnt_reg == l3_ext - 16'd1) begin
                    if (is_tag) begin
                        tags_next = tags_reg + TAG_W'(1);
                        l3_next   = l3_reg + TAG_LEN;
                    end else if (etype == ETYPE_IPV4) begin
                        phase_next = PH_IP;
                    end else begin
                        phase_next = PH_OTHER;
                    end
                end
            end
            PH_IP: begin
                if (cnt_reg >= l3_ext) begin
                    if (ip_off == 16'd0) begin
                        ver_ok_next = (beat.data[7:4] == 4'd4);
                        ihl_next    = {beat.data[3:0], 2'b00};
                    end
                    if (ip_off == 16'd6) frag_hi_next = (beat.data[5:0] != 6'd0);
                    if (ip_off == 16'd7) frag_lo_next = (beat.data != 8'd0);
                    if (ip_off == 16'd9) proto_next = beat.data;
                    if (ip_off >= 16'd12 && ip_off <= 16'd15) begin
                        src_addr_next = {src_addr_reg[23:0], beat.data};
                    end
                    if (ip_off >= 16'd16 && ip_off <= 16'd19) begin
                        dst_addr_next = {dst_addr_reg[23:0], beat.data};
                    end
                    // The L4 ports sit in the four bytes right after the IPv4 header.
                    if (ip_off[15:6] == 10'd0 && port_off[6:2] == 5'd0) begin
                        if (port_off[1]) begin
                            dst_port_next = {dst_port_reg[7:0], beat.data};
                        end else begin
                            src_port_next = {src_port_reg[7:0], beat.data};
                        end
                    end
                end
            end
            PH_OTHER: begin
            end
            default: begin
            end
        endcase
    end

    // Frame-end checks, taken on the state as updated by the last byte itself.
    always_comb begin
        len        = cnt_next;
        l3_new     = {{(7 - L3_W){1'b0}}, l3_next};
        ip_min_end = l3_new + IP_MIN_LEN;
        hdr_end    = l3_new + {1'b0, ihl_next};
        if (proto_next == PROTO_TCP) begin
            need = TCP_HDR_LEN;
        end else if (proto_next == PROTO_UDP) begin
            need = UDP_HDR_LEN;
        end else begin
            need = 7'd0;
        end
        l4_end = hdr_end + need;

        if (phase_next == PH_ETH) begin
            status = ST_TRUNC;
        end else if (phase_next != PH_IP) begin
            status = ST_NOT_IPV4;
        end else if (len < {9'd0, ip_min_end}) begin
            status = ST_TRUNC;
        end else if (!ver_ok_next) begin
            status = ST_BAD_HDR;
        end else if (ihl_next < IP_MIN_LEN[5:0]) begin
            status = ST_BAD_HDR;
        end else if (len < {9'd0, hdr_end}) begin
            status = ST_TRUNC;
        end else if (frag_hi_next || frag_lo_next) begin
            status = ST_BAD_HDR;
        end else begin
            status = ST_PARSED;
        end
        ports_ok = (status == ST_PARSED) && (need != 7'd0) && (len >= {9'd0, l4_end});

        res.parse_status   = status;
        res.source_address = (status == ST_PARSED) ? src_addr_next : 32'd0;
        res.dest_address   = (status == ST_PARSED) ? dst_addr_next : 32'd0;
        res.source_port    = ports_ok ? src_port_next : 16'd0;
        res.dest_port      = ports_ok ? dst_port_next : 16'd0;
        res.ip_protocol    = (status == ST_PARSED) ? proto_next : 8'd0;
        res.frame_length   = len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ETH;
            cnt_reg   <= 16'd0;
            tags_reg  <= '0;
            l3_reg    <= L3_BASE;
        end else if (consume) begin
            if (beat.last) begin
                phase_reg <= PH_ETH;
                cnt_reg   <= 16'd0;
                tags_reg  <= '0;
                l3_reg    <= L3_BASE;
            end else begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                tags_reg  <= tags_next;
                l3_reg    <= l3_next;
            end
        end
        if (consume) begin
            etype_hi_reg <= etype_hi_next;
            ver_ok_reg   <= ver_ok_next;
            ihl_reg      <= ihl_next;
            frag_hi_reg  <= frag_hi_next;
            frag_lo_reg  <= frag_lo_next;
            proto_reg    <= proto_next;
            src_addr_reg <= src_addr_next;
            dst_addr_reg <= dst_addr_next;
            src_port_reg <= src_port_next;
            dst_port_reg <= dst_port_next;
        end
    end

endmodule

>>> src/ipv4ft_out_reg.sv
// Result register of the IPv4 five-tuple header parser.
// Holds one result until the downstream side takes it; uses ipv4ft_pkg.
module ipv4ft_out_reg import ipv4ft_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              res,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
        if (free && load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), res_reg};

endmodule

>>> src/ipv4_five_tuple_header_parser.sv
// Top level of the IPv4 five-tuple header parser: configuration registers and channel wiring.
// Depends on ipv4ft_pkg, ipv4ft_in_stage, ipv4ft_parser, ipv4ft_out_reg and the macros header.
//
// Usage:
// The slave channel carries an Ethernet frame one byte per transaction, wire order,
// with s_tlast high on the final byte. For every frame the master channel carries
// exactly one result transaction: status, IPv4 source and destination address,
// L4 ports, protocol and the saturating byte count of the frame.
// The block takes one byte every cycle unless a frame's last byte is held. Each byte passes
// through an input register and one short compare-and-capture step into the parse state.
// m_tvalid rises once the last byte of the frame has been loaded into the result register.
// When the receiver stalls, non-final bytes keep flowing; only a frame's last byte
// waits in the input register until the result register has room, which stalls
// s_tready for as long as the held result is not taken.
// The configuration channel writes the two VLAN tag types (index 0 and 1); it is
// always ready and is meant to be used only between frames.
// A synchronous low aresetn empties both registers, restores the default tag types
// (0x8100 and 0x88A8) and returns the parser to the start of a frame.
`include "ipv4_five_tuple_header_parser_macros.svh"

module ipv4_five_tuple_header_parser import ipv4ft_pkg::*; #(
    parameter int MAX_VLAN_TAGS = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Slave stream: tdata = frame_byte[7:0]; tlast = last_byte.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    // Master stream: tdata from bit 0 up = parse_status[2], source_address[32],
    // dest_address[32], source_port[16], dest_port[16], ip_protocol[8],
    // frame_length[16], zero fill[6].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0] tag_a_reg;
    logic [15:0] tag_b_reg;
    in_beat_t    beat;
    logic        consume;
    logic        res_load;
    logic        out_free;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= TAG_A_RESET;
            tag_b_reg <= TAG_B_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TAG_A: tag_a_reg <= cfg_data;
                CFG_TAG_B: tag_b_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ipv4ft_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .consume  (consume),
        .beat     (beat)
    );

    ipv4ft_parser #(
        .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tag_type_a (tag_a_reg),
        .tag_type_b (tag_b_reg),
        .beat       (beat),
        .out_free   (out_free),
        .consume    (consume),
        .res_load   (res_load),
        .res        (res)
    );

    ipv4ft_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A result that did not parse carries no addresses, ports or protocol.
    `IPV4FT_ASSERT_IMPL(a_unparsed_zero, m_tvalid && (m_tdata[1:0] != ST_PARSED),
        (m_tdata[105:2] == 104'd0))
    // Nonzero ports only come with a parsed TCP or UDP header.
    `IPV4FT_ASSERT_IMPL(a_ports_tcp_udp, m_tvalid && (m_tdata[97:66] != 32'd0),
        (m_tdata[1:0] == ST_PARSED) &&
        ((m_tdata[105:98] == PROTO_TCP) || (m_tdata[105:98] == PROTO_UDP)))
    // A parsed frame holds at least an Ethernet header and a minimal IPv4 header.
    `IPV4FT_ASSERT_IMPL(a_parsed_len, m_tvalid && (m_tdata[1:0] == ST_PARSED),
        (m_tdata[121:106] >= 16'd34))
    // Each last byte taken by the parse stage puts a result on the master side.
    `IPV4FT_ASSERT_NEXT(a_last_gives_result, res_load, m_tvalid)

endmodule
